[hdl/multi_channel_alarm_timer_defines.svh]
// Assertion macros for the alarm timer, used by the top level to check its own logic.
`ifndef MULTI_CHANNEL_ALARM_TIMER_DEFINES_SVH
`define MULTI_CHANNEL_ALARM_TIMER_DEFINES_SVH

// Check on every clock edge outside reset
`define MCAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also holds through reset
`define MCAT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/mcat_pkg.sv]
// Types and codes for the multi-channel alarm timer.
`default_nettype none

package mcat_pkg;

  // Command codes of an input beat
  typedef enum logic [1:0] {
    CMD_SET    = 2'd0,
    CMD_CANCEL = 2'd1,
    CMD_TICK   = 2'd2
  } cmd_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_OK      = 2'd0,
    KIND_INVALID = 2'd1,
    KIND_FIRED   = 2'd2,
    KIND_DONE    = 2'd3
  } kind_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CMD,
    S_SCAN,
    S_EVAL,
    S_DONE
  } state_t;

  // One channel entry in the table memory
  typedef struct packed {
    logic [15:0] reload;
    logic [15:0] count;
    logic [7:0]  tgt_task;
    logic        autorl;
  } chan_entry_t;

endpackage

`default_nettype wire

[hdl/mcat_if.sv]
// Valid/ready channel interfaces for command beats and result beats.
`default_nettype none

interface mcat_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [7:0]  alarm_index;
  logic [15:0] tick_count;
  logic [7:0]  task_id;
  logic        autoreload;

  modport source (output valid, output cmd, output alarm_index, output tick_count,
                  output task_id, output autoreload, input ready);
  modport sink   (input valid, input cmd, input alarm_index, input tick_count,
                  input task_id, input autoreload, output ready);
endinterface

interface mcat_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [2:0] fired_alarm;
  logic [7:0] fired_task;
  logic       any_fired;
  logic       last;

  modport source (output valid, output kind, output fired_alarm, output fired_task,
                  output any_fired, output last, input ready);
  modport sink   (input valid, input kind, input fired_alarm, input fired_task,
                  input any_fired, input last, output ready);
endinterface

`default_nettype wire

[hdl/multi_channel_alarm_timer.sv]
// Multi-channel alarm timer top level: sequencer plus channel table memory.
//
// Channel   Dir  Beat contents
// in_ch     in   cmd, alarm_index, tick_count, task_id, autoreload
// out_ch    out  kind, fired_alarm, fired_task, any_fired, last
//
// Set and cancel: the beat is checked in S_CMD and the result is loaded once the
// result register is free. Tick: after S_IDLE takes the beat, S_SCAN skips each
// inactive channel; an active channel is read in S_SCAN, then decremented and written
// back in S_EVAL; S_DONE emits the done result. One command is in flight.
// Reset clears all active bits at once; no memory clearing pass is needed.
// A stalled result register holds the sequencer only when it must emit.
`default_nettype none
`include "multi_channel_alarm_timer_defines.svh"

module multi_channel_alarm_timer #(
  parameter int CHANNELS    = 8,
  parameter int MAX_TASK_ID = 8
) (
  input  wire         clk,
  input  wire         rst_n,
  mcat_in_if.sink     in_ch,
  mcat_out_if.source  out_ch
);
  import mcat_pkg::*;

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic          wr_en;
  logic [CW-1:0] wr_addr;
  chan_entry_t   wr_data;
  logic          rd_en;
  logic [CW-1:0] rd_addr;
  chan_entry_t   rd_data;

  // Sequencer
  mcat_ctrl #(
    .CHANNELS    (CHANNELS),
    .MAX_TASK_ID (MAX_TASK_ID),
    .CW          (CW)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Channel table
  mcat_mem #(
    .DEPTH (CHANNELS),
    .AW    (CW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Checks
  `MCAT_ASSERT(a_one_in_flight, in_ch.valid && in_ch.ready |=> !in_ch.ready, "beat taken busy")
  `MCAT_ASSERT(a_last_kind, out_ch.valid |-> (out_ch.last == (out_ch.kind != KIND_FIRED)), "bad last")
  `MCAT_ASSERT_RST(a_reset_quiet, !rst_n |=> !out_ch.valid, "result valid after reset")

endmodule

`default_nettype wire

[hdl/mcat_mem.sv]
// Channel table memory: one write port, one registered read port.
`default_nettype none

module mcat_mem #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  wire                       clk,
  input  wire                       wr_en,
  input  wire  [AW-1:0]             wr_addr,
  input  mcat_pkg::chan_entry_t     wr_data,
  input  wire                       rd_en,
  input  wire  [AW-1:0]             rd_addr,
  output mcat_pkg::chan_entry_t     rd_data
);
  import mcat_pkg::*;

  chan_entry_t mem_r [DEPTH];
  chan_entry_t rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[hdl/mcat_ctrl.sv]
// Command sequencer: argument checks, tick scan with read-modify-write, result register.
`default_nettype none

module mcat_ctrl #(
  parameter int CHANNELS    = 8,
  parameter int MAX_TASK_ID = 8,
  parameter int CW          = 3
) (
  input  wire                   clk,
  input  wire                   rst_n,
  mcat_in_if.sink               in_ch,
  mcat_out_if.source            out_ch,
  output logic                  wr_en,
  output logic [CW-1:0]         wr_addr,
  output mcat_pkg::chan_entry_t wr_data,
  output logic                  rd_en,
  output logic [CW-1:0]         rd_addr,
  input  mcat_pkg::chan_entry_t rd_data
);
  import mcat_pkg::*;

  localparam logic [CW-1:0] CH_LAST = CW'(CHANNELS - 1);

  // Control state
  state_t              state_r, state_nxt;
  logic [CW-1:0]       ch_r, ch_nxt;
  logic                any_r, any_nxt;
  logic [CHANNELS-1:0] active_r, active_nxt;

  // Captured command beat
  logic [1:0]  cmd_r;
  logic [7:0]  idx_r;
  logic [15:0] ticks_r;
  logic [7:0]  task_r;
  logic        autorl_r;

  // Result register
  logic        out_valid_r;
  kind_t       kind_r;
  logic [2:0]  alarm_r;
  logic [7:0]  ftask_r;
  logic        any_o_r;
  logic        last_r;

  // Result to load this cycle
  logic        emit;
  kind_t       e_kind;
  logic [2:0]  e_alarm;
  logic [7:0]  e_task;
  logic        e_any;
  logic        e_last;

  logic        out_free;
  logic        idx_ok;
  logic        set_ok;
  logic [CW-1:0] idx_ch;
  logic [15:0] dec;

  assign out_free = !out_valid_r || out_ch.ready;
  assign idx_ok   = idx_r < 8'(CHANNELS);
  assign set_ok   = idx_ok && (ticks_r != 16'd0) && (task_r <= 8'(MAX_TASK_ID));
  assign idx_ch   = idx_r[CW-1:0];
  assign dec      = rd_data.count - 16'd1;

  // Next state, memory access and result selection
  always_comb begin
    state_nxt    = state_r;
    ch_nxt       = ch_r;
    any_nxt      = any_r;
    active_nxt   = active_r;
    in_ch.ready  = 1'b0;
    emit         = 1'b0;
    e_kind       = KIND_OK;
    e_alarm      = 3'd0;
    e_task       = 8'd0;
    e_any        = 1'b0;
    e_last       = 1'b1;
    wr_en        = 1'b0;
    wr_addr      = ch_r;
    wr_data      = rd_data;
    rd_en        = 1'b0;
    rd_addr      = ch_r;

    unique case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          if (in_ch.cmd == CMD_TICK) begin
            ch_nxt    = CH_LAST;
            any_nxt   = 1'b0;
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_CMD;
          end
        end
      end

      S_CMD: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
          unique case (cmd_r)
            CMD_SET: begin
              if (set_ok) begin
                wr_en              = 1'b1;
                wr_addr            = idx_ch;
                wr_data.reload     = ticks_r;
                wr_data.count      = ticks_r;
                wr_data.tgt_task   = task_r;
                wr_data.autorl     = autorl_r;
                active_nxt[idx_ch] = 1'b1;
              end else begin
                e_kind = KIND_INVALID;
              end
            end
            CMD_CANCEL: begin
              if (idx_ok) begin
                active_nxt[idx_ch] = 1'b0;
              end else begin
                e_kind = KIND_INVALID;
              end
            end
            default: begin
              e_kind = KIND_INVALID;
            end
          endcase
        end
      end

      // Skip inactive channels, fetch active ones
      S_SCAN: begin
        if (active_r[ch_r]) begin
          rd_en     = 1'b1;
          state_nxt = S_EVAL;
        end else if (ch_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          ch_nxt = ch_r - 1'b1;
        end
      end

      // Decrement and write back; an expiry waits for the result register
      S_EVAL: begin
        if (dec != 16'd0) begin
          wr_en         = 1'b1;
          wr_data.count = dec;
          if (ch_r == '0) begin
            state_nxt = S_DONE;
          end else begin
            ch_nxt    = ch_r - 1'b1;
            state_nxt = S_SCAN;
          end
        end else if (out_free) begin
          emit          = 1'b1;
          e_kind        = KIND_FIRED;
          e_alarm       = 3'(ch_r);
          e_task        = rd_data.tgt_task;
          e_last        = 1'b0;
          any_nxt       = 1'b1;
          wr_en         = 1'b1;
          wr_data.count = rd_data.autorl ? rd_data.reload : dec;
          if (!rd_data.autorl) begin
            active_nxt[ch_r] = 1'b0;
          end
          if (ch_r == '0) begin
            state_nxt = S_DONE;
          end else begin
            ch_nxt    = ch_r - 1'b1;
            state_nxt = S_SCAN;
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          emit      = 1'b1;
          e_kind    = KIND_DONE;
          e_any     = any_r;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ch_r     <= '0;
      any_r    <= 1'b0;
      active_r <= '0;
    end else begin
      state_r  <= state_nxt;
      ch_r     <= ch_nxt;
      any_r    <= any_nxt;
      active_r <= active_nxt;
    end
  end

  // Command capture
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      cmd_r    <= in_ch.cmd;
      idx_r    <= in_ch.alarm_index;
      ticks_r  <= in_ch.tick_count;
      task_r   <= in_ch.task_id;
      autorl_r <= in_ch.autoreload;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind_r  <= e_kind;
      alarm_r <= e_alarm;
      ftask_r <= e_task;
      any_o_r <= e_any;
      last_r  <= e_last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = kind_r;
  assign out_ch.fired_alarm = alarm_r;
  assign out_ch.fired_task  = ftask_r;
  assign out_ch.any_fired   = any_o_r;
  assign out_ch.last        = last_r;

endmodule

`default_nettype wire
